/* rtl/ewa_pkg.sv */
// Shared types and constants for the encoder wrap accumulator.
// No dependencies; all other files but ewa_if import this package.
`timescale 1ns / 1ps
`default_nettype none
package ewa_pkg;

	localparam int COUNTER_BITS = 32;
	localparam logic [32:0] CntMaskWide = (33'd1 << COUNTER_BITS) - 33'd1;
	localparam logic [31:0] CntMask = CntMaskWide[31:0];

	localparam logic [31:0] ReloadReset    = 32'd65535;
	localparam logic [15:0] ThresholdReset = 16'd5;
	localparam logic [7:0]  RunLenReset    = 8'd20;

	typedef enum logic [1:0] {
		RegReload    = 2'd0,
		RegThreshold = 2'd1,
		RegRunLength = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OpSample = 1'b0,
		OpZero   = 1'b1
	} op_t;

	typedef struct packed {
		logic [31:0] reload_value;
		logic [15:0] still_threshold;
		logic [7:0]  still_run_length;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] step_change;
		logic [7:0]         still_run;
		logic               stalled;
	} res_t;

endpackage
`default_nettype wire

/* rtl/ewa_if.sv */
// Valid/ready channel interfaces for counter snapshots and position results.
// Depends on nothing; field widths follow the block's item definitions.
`timescale 1ns / 1ps
`default_nettype none
interface ewa_sample_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] counter_value;

	modport source (output valid, output op, output counter_value, input ready);
	modport sink (input valid, input op, input counter_value, output ready);
endinterface

interface ewa_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;
	logic signed [31:0] step_change;
	logic [7:0]         still_run;
	logic               stalled;

	modport source (output valid, output position, output step_change,
		output still_run, output stalled, input ready);
	modport sink (input valid, input position, input step_change,
		input still_run, input stalled, output ready);
endinterface
`default_nettype wire

/* rtl/ewa_cfg.sv */
// Configuration register file: reload value, still threshold and run length.
// Depends on ewa_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none
module ewa_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output ewa_pkg::cfg_t     cfg
);
	import ewa_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reload_value     <= ReloadReset;
			cfg_q.still_threshold  <= ThresholdReset;
			cfg_q.still_run_length <= RunLenReset;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				RegReload:    cfg_q.reload_value     <= cfg_data;
				RegThreshold: cfg_q.still_threshold  <= cfg_data[15:0];
				RegRunLength: cfg_q.still_run_length <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/ewa_core.sv */
// Unwrap datapath: holds reference, last relative count, position and still run,
// and forms one result per item. Depends on ewa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ewa_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ewa_pkg::cfg_t cfg,
	input  wire logic          en,
	input  wire logic          op,
	input  wire logic [31:0]   counter_value,
	output ewa_pkg::res_t      res
);
	import ewa_pkg::*;

	logic [31:0] zero_ref_q;
	logic [31:0] last_rel_q;
	logic [31:0] acc_q;
	logic [7:0]  still_q;

	logic [31:0]        cnt;
	logic [31:0]        rel;
	logic [31:0]        chg;
	logic [32:0]        span;
	logic signed [33:0] chg_x;
	logic signed [33:0] half_x;
	logic               fold_dn;
	logic               fold_up;
	logic [31:0]        step;
	logic [31:0]        mag;
	logic               still_hit;
	logic [8:0]         run_inc;
	logic [7:0]         run_next;
	logic [31:0]        acc_next;

	always_comb begin
		cnt      = counter_value & CntMask;
		rel      = cnt - zero_ref_q;
		chg      = rel - last_rel_q;
		span     = {1'b0, cfg.reload_value} + 33'd1;
		chg_x    = {{2{chg[31]}}, chg};
		half_x   = {2'b00, span[32:1]};
		fold_dn  = chg_x > half_x;
		fold_up  = chg_x < -half_x;
		// Only the low 32 bits of the span matter once the result wraps.
		if (fold_dn) begin
			step = chg - span[31:0];
		end else if (fold_up) begin
			step = chg + span[31:0];
		end else begin
			step = chg;
		end
		mag       = step[31] ? (32'd0 - step) : step;
		still_hit = mag < {16'd0, cfg.still_threshold};
		run_inc   = {1'b0, still_q} + 9'd1;
		// Clamping also pulls the run down when the length register was lowered.
		if (!still_hit) begin
			run_next = 8'd0;
		end else if (run_inc > {1'b0, cfg.still_run_length}) begin
			run_next = cfg.still_run_length;
		end else begin
			run_next = run_inc[7:0];
		end
		acc_next = acc_q + step;

		if (op_t'(op) == OpZero) begin
			res.position    = '0;
			res.step_change = '0;
			res.still_run   = '0;
			res.stalled     = (cfg.still_run_length == 8'd0);
		end else begin
			res.position    = acc_next;
			res.step_change = step;
			res.still_run   = run_next;
			res.stalled     = (run_next >= cfg.still_run_length);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_ref_q <= '0;
			last_rel_q <= '0;
			acc_q      <= '0;
			still_q    <= '0;
		end else if (en) begin
			if (op_t'(op) == OpZero) begin
				zero_ref_q <= cnt;
				last_rel_q <= '0;
				acc_q      <= '0;
				still_q    <= '0;
			end else begin
				last_rel_q <= rel;
				acc_q      <= acc_next;
				still_q    <= run_next;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/encoder_wrap_accumulator_stall.sv */
// Encoder position unwrap with stall detection, top level.
// A word is registered in the input stage, then its result in the output register.
// Throughput: one word per cycle unless output is blocked; ewa_core updates state.
// Reset clears the pipeline valids, the unwrap state, and loads the register defaults.
// Depends on ewa_pkg, ewa_if, ewa_cfg and ewa_core.
`timescale 1ns / 1ps
`default_nettype none
module encoder_wrap_accumulator_stall (
	input  wire logic         clk,
	input  wire logic         arst_n,
	ewa_sample_if.sink        sample,
	ewa_result_if.source      result,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import ewa_pkg::*;

	cfg_t        cfg;
	res_t        res;
	logic        valid_s1;
	logic        op_s1;
	logic [31:0] cnt_s1;
	logic        out_valid_q;
	res_t        out_q;
	logic        adv;

	// The input stage moves on whenever the result register is empty or draining.
	assign adv          = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv;

	ewa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ewa_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.en            (adv),
		.op            (op_s1),
		.counter_value (cnt_s1),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			op_s1  <= sample.op;
			cnt_s1 <= sample.counter_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.position    = out_q.position;
	assign result.step_change = out_q.step_change;
	assign result.still_run   = out_q.still_run;
	assign result.stalled     = out_q.stalled;

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("input stage word dropped while the result register was blocked");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not filled after the input stage advanced");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result.ready && !adv) |=> !out_valid_q)
		else $error("result word repeated after it was taken");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> valid_s1)
		else $error("accepted word missing from the input stage");

endmodule
`default_nettype wire

/* tb/sv/encoder_wrap_accumulator_stall_test.sv */
// Self-checking testbench for the encoder wrap accumulator: directed corner cases,
// back-pressure and randomized encoder motion, checked against an in-bench unwrap model.
// Depends on ewa_pkg, ewa_if and encoder_wrap_accumulator_stall from the RTL.
`timescale 1ns / 1ps
module encoder_wrap_accumulator_stall_test;
	import ewa_pkg::*;

	localparam int QuietLimit = 4000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	ewa_sample_if sample_ch ();
	ewa_result_if result_ch ();

	encoder_wrap_accumulator_stall dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Unwrap model state and its copy of the registers.
	logic [31:0] ref_point;
	logic [31:0] prev_rel;
	logic [31:0] pos_acc;
	logic [7:0]  still_cnt;
	logic [31:0] cfg_reload;
	logic [15:0] cfg_thr;
	logic [7:0]  cfg_run;

	res_t pending_positions[$];
	res_t want_res;
	int   mismatches;
	int   sender_idle_pct;
	int   stall_pct;
	int   hold_cycles;
	longint enc_pos;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic res_t unwrap_position(op_t op, logic [31:0] raw);
		logic [31:0] cnt, rel, diff, step, mag;
		logic signed [63:0] delta, span, half;
		logic [8:0] next_run;
		res_t r;
		cnt = raw & CntMask;
		if (op == OpZero) begin
			ref_point = cnt;
			prev_rel = '0;
			pos_acc = '0;
			still_cnt = '0;
			step = '0;
		end else begin
			rel = cnt - ref_point;
			diff = rel - prev_rel;
			delta = {{32{diff[31]}}, diff};
			span = {32'd0, cfg_reload};
			span = span + 64'sd1;
			half = span >>> 1;
			if (delta > half)
				delta = delta - span;
			else if (delta < -half)
				delta = delta + span;
			step = delta[31:0];
			prev_rel = rel;
			pos_acc = pos_acc + step;
			mag = step[31] ? (32'd0 - step) : step;
			if (mag < {16'd0, cfg_thr}) begin
				next_run = {1'b0, still_cnt} + 9'd1;
				if (next_run > {1'b0, cfg_run})
					next_run = {1'b0, cfg_run};
				still_cnt = next_run[7:0];
			end else begin
				still_cnt = '0;
			end
		end
		r.position = pos_acc;
		r.step_change = step;
		r.still_run = still_cnt;
		r.stalled = (still_cnt >= cfg_run);
		return r;
	endfunction

	// Predict on every accepted input word and track register writes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_point <= '0;
			prev_rel <= '0;
			pos_acc <= '0;
			still_cnt <= '0;
			cfg_reload <= ReloadReset;
			cfg_thr <= ThresholdReset;
			cfg_run <= RunLenReset;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					RegReload:    cfg_reload = cfg_data;
					RegThreshold: cfg_thr = cfg_data[15:0];
					RegRunLength: cfg_run = cfg_data[7:0];
					default: ;
				endcase
			end
			if (sample_ch.valid && sample_ch.ready)
				pending_positions.push_back(unwrap_position(op_t'(sample_ch.op),
					sample_ch.counter_value));
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_positions.size() == 0) begin
				$error("unexpected result word: position %0d step %0d",
					result_ch.position, result_ch.step_change);
				mismatches++;
			end else begin
				want_res = pending_positions.pop_front();
				if (result_ch.position !== want_res.position) begin
					$error("position: expected %0d, got %0d", want_res.position,
						result_ch.position);
					mismatches++;
				end
				if (result_ch.step_change !== want_res.step_change) begin
					$error("step_change: expected %0d, got %0d", want_res.step_change,
						result_ch.step_change);
					mismatches++;
				end
				if (result_ch.still_run !== want_res.still_run) begin
					$error("still_run: expected %0d, got %0d", want_res.still_run,
						result_ch.still_run);
					mismatches++;
				end
				if (result_ch.stalled !== want_res.stalled) begin
					$error("stalled: expected %0b, got %0b", want_res.stalled,
						result_ch.stalled);
					mismatches++;
				end
			end
		end
	end

	// Receiver: a requested hold-off takes precedence over random stalls.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_ch.ready = 1'b0;
				hold_cycles--;
			end else begin
				result_ch.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
					|| cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	task automatic send_word(op_t op, logic [31:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.op = op;
		sample_ch.counter_value = value;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
		sample_ch.valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		wait_idle();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Encoder-like motion: the counter stays inside the reload span and mostly
	// moves by small steps, with some jumps near half a span and raw noise.
	task automatic run_motion(int count);
		longint span, half, delta;
		int pick;
		for (int i = 0; i < count; i++) begin
			span = {32'd0, cfg_reload};
			span = span + 1;
			half = span / 2;
			pick = $urandom_range(99);
			if (pick < 3) begin
				send_word(OpZero, $urandom_range(1) ? $urandom : enc_pos[31:0]);
			end else if (pick < 10) begin
				send_word(OpSample, $urandom);
			end else begin
				pick = $urandom_range(99);
				if (pick < 55)
					delta = (cfg_thr == 0) ? 0 : longint'($urandom_range(cfg_thr - 1, 0));
				else if (pick < 85)
					delta = longint'($urandom_range(2000));
				else if (pick < 95)
					delta = half + longint'($urandom_range(4)) - 2;
				else
					delta = {32'd0, $urandom} % span;
				if ($urandom_range(1))
					delta = -delta;
				enc_pos = (enc_pos + delta) % span;
				if (enc_pos < 0)
					enc_pos = enc_pos + span;
				send_word(OpSample, enc_pos[31:0]);
			end
		end
	endtask

	task automatic pick_config(int kind);
		longint span;
		case (kind)
			0: begin
				write_reg(RegReload, 32'd65535);
				write_reg(RegThreshold, 32'd5);
				write_reg(RegRunLength, 32'd20);
			end
			1: begin
				write_reg(RegReload, 32'hFFFF_FFFF);
				write_reg(RegThreshold, 32'd65535);
				write_reg(RegRunLength, 32'd255);
			end
			2: begin
				write_reg(RegReload, 32'd1);
				write_reg(RegThreshold, $urandom_range(2));
				write_reg(RegRunLength, 32'd1);
			end
			4: begin
				write_reg(RegReload, $urandom_range(32'hFFFF_FFFF, 1));
				write_reg(RegThreshold, $urandom_range(65535));
				write_reg(RegRunLength, $urandom_range(255, 1));
			end
			5: begin
				write_reg(RegReload, $urandom_range(15, 3));
				write_reg(RegThreshold, $urandom_range(4, 1));
				write_reg(RegRunLength, $urandom_range(8, 2));
			end
			default: begin
				write_reg(RegReload, $urandom_range(200000, 2));
				write_reg(RegThreshold, $urandom_range(300, 1));
				write_reg(RegRunLength, $urandom_range(40, 1));
			end
		endcase
		span = {32'd0, cfg_reload};
		span = span + 1;
		enc_pos = enc_pos % span;
		send_word(OpZero, enc_pos[31:0]);
	endtask

	task automatic test_reset_defaults();
		send_word(OpSample, 32'd3);
		send_word(OpSample, 32'd3);
		// A change of exactly half a span is kept, one more is folded back.
		send_word(OpSample, 32'h0000_8003);
		send_word(OpSample, 32'd3);
		send_word(OpSample, 32'h0000_8004);
		send_word(OpZero, 32'hFFFF_FFFF);
		send_word(OpSample, 32'd0);
		send_word(OpSample, 32'hFFFF_FFFE);
	endtask

	task automatic test_fold_extremes();
		write_reg(RegReload, 32'hFFFF_FFFF);
		write_reg(RegThreshold, 32'hFFFF);
		send_word(OpZero, 32'd0);
		// Most negative change: its magnitude is 2^31, never still.
		send_word(OpSample, 32'h8000_0000);
		send_word(OpSample, 32'h7FFF_FFFF);
		write_reg(RegReload, 32'd1);
		write_reg(RegThreshold, 32'd1);
		send_word(OpSample, 32'h8000_0001);
		send_word(OpSample, 32'h8000_0000);
		write_reg(RegThreshold, 32'd0);
		send_word(OpSample, 32'h8000_0000);
	endtask

	task automatic test_run_saturation();
		write_reg(RegReload, 32'd65535);
		write_reg(RegThreshold, 32'hFFFF);
		write_reg(RegRunLength, 32'd3);
		send_word(OpZero, 32'd0);
		repeat (4) send_word(OpSample, 32'd0);
		// Lowering the run length below the current run clamps it.
		write_reg(RegRunLength, 32'd1);
		send_word(OpSample, 32'd0);
		// With a zero run length the block always reports a stall.
		write_reg(RegRunLength, 32'd0);
		send_word(OpSample, 32'd0);
		send_word(OpZero, 32'd7);
		write_reg(RegRunLength, 32'd255);
	endtask

	task automatic test_backpressure();
		sender_idle_pct = 0;
		stall_pct = 0;
		enc_pos = 0;
		hold_cycles = 200;
		run_motion(40);
		wait_idle();
		sender_idle_pct = 30;
		hold_cycles = 60;
		run_motion(30);
		wait_idle();
	endtask

	task automatic test_random_motion();
		int sender_pcts[4] = '{0, 74, 0, 30};
		int stall_pcts[4] = '{0, 0, 74, 30};
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = sender_pcts[p];
			stall_pct = stall_pcts[p];
			for (int s = 0; s < 2; s++) begin
				pick_config(2 * p + s);
				run_motion(200);
			end
		end
		sender_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.op = OpSample;
		sample_ch.counter_value = '0;
		mismatches = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		enc_pos = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_fold_extremes();
		test_run_saturation();
		test_backpressure();
		test_random_motion();

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
